[design/joybus_controller_responder_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the controller responder core
// Gives labeled concurrent assertion forms that can be compiled out.
// ----------------------------------------------------------------------------
`ifndef JOYBUS_CONTROLLER_RESPONDER_CORE_DEFINES_SVH
`define JOYBUS_CONTROLLER_RESPONDER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define JBCR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define JBCR_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define JBCR_ASSERT(label, clk, rst, prop)
`define JBCR_NEVER(label, clk, rst, cond)
`endif

`endif

[design/jbcr_pkg.sv]
// ----------------------------------------------------------------------------
// Controller responder package
// Shared types, codes and reply tables of the controller responder core.
// ----------------------------------------------------------------------------
`default_nettype none

package jbcr_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_FACE_MASK = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOULDER_MASK = 8'd1;

  localparam logic [7:0] RX_MASK = 8'h52;
  localparam logic [7:0] RX_STOP = 8'h52;
  localparam logic [7:0] RX_PAIR_01 = 8'h40;
  localparam logic [7:0] RX_PAIR_10 = 8'h02;
  localparam logic [7:0] RX_PAIR_11 = 8'h42;

  localparam logic [7:0] CMD_POLL = 8'h00;
  localparam logic [7:0] CMD_STATUS = 8'h40;
  localparam logic [7:0] CMD_ORIGIN = 8'h41;

  localparam logic [7:0] TX_STOP = 8'hFF;
  localparam logic [7:0] STATUS_FIXED_BIT = 8'h80;

  localparam logic [3:0] POLL_BYTES = 4'd3;
  localparam logic [3:0] STATUS_BYTES = 4'd8;
  localparam logic [3:0] ORIGIN_BYTES = 4'd10;

  typedef struct packed {
    logic [7:0]  rx_symbol;
    logic [15:0] button_pins;
    logic [3:0]  dpad_bits;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic [7:0]  cstick_x;
    logic [7:0]  cstick_y;
    logic [7:0]  trigger_left;
    logic [7:0]  trigger_right;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_symbol;
    logic       last_symbol;
    logic       rumble_on;
  } out_item_t;

  typedef enum logic [1:0] {
    REPLY_POLL,
    REPLY_ORIGIN,
    REPLY_STATUS
  } reply_kind_t;

  typedef struct packed {
    reply_kind_t      kind;
    logic             rumble;
    logic [7:0][7:0]  data;
  } reply_job_t;

  function automatic logic [7:0] pair_code(input logic [1:0] pair);
    logic [7:0] code;
    case (pair)
      2'd0: code = 8'h08;
      2'd1: code = 8'hE8;
      2'd2: code = 8'h0F;
      default: code = 8'hEF;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] poll_byte(input logic [3:0] idx);
    logic [7:0] value;
    case (idx)
      4'd0: value = 8'h09;
      4'd2: value = 8'h03;
      default: value = 8'h00;
    endcase
    return value;
  endfunction

  function automatic logic [7:0] origin_byte(input logic [3:0] idx);
    logic [7:0] value;
    case (idx)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5: value = 8'h80;
      default: value = 8'h00;
    endcase
    return value;
  endfunction

endpackage

`default_nettype wire

[design/jbcr_front.sv]
// ----------------------------------------------------------------------------
// Controller responder front end
// Decodes received symbols, assembles command bytes and queues reply jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module jbcr_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire jbcr_pkg::in_item_t               item,
  input  wire logic                             cfg_write,
  input  wire logic [jbcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data,
  output      logic                             job_push,
  output      jbcr_pkg::reply_job_t             job
);

  typedef enum logic [1:0] {
    CMD_BYTE,
    MID_BYTE,
    LAST_BYTE
  } phase_t;

  phase_t      phase;
  logic [1:0]  pair_index;
  logic [5:0]  partial_byte;
  logic        rumble_state;
  logic [15:0] face_button_mask;
  logic [15:0] shoulder_button_mask;

  logic [7:0]  masked;
  logic        is_stop;
  logic [1:0]  bits;
  logic [7:0]  new_byte;
  logic        byte_done;
  logic [15:0] pins_low;
  logic [15:0] shoulder_bits;

  always_comb begin
    masked = item.rx_symbol & jbcr_pkg::RX_MASK;
    is_stop = (masked == jbcr_pkg::RX_STOP);
    case (masked)
      jbcr_pkg::RX_PAIR_01: bits = 2'd1;
      jbcr_pkg::RX_PAIR_10: bits = 2'd2;
      jbcr_pkg::RX_PAIR_11: bits = 2'd3;
      default: bits = 2'd0;
    endcase
    new_byte = {partial_byte, bits};
    byte_done = accept && !is_stop && (pair_index == 2'd3);
    pins_low = ~item.button_pins;
    shoulder_bits = (pins_low & shoulder_button_mask) >> 1;

    job_push = 1'b0;
    job.kind = jbcr_pkg::REPLY_POLL;
    job.rumble = rumble_state;
    job.data[0] = pins_low[7:0] & face_button_mask[7:0];
    job.data[1] = shoulder_bits[7:0] | jbcr_pkg::STATUS_FIXED_BIT | {4'd0, item.dpad_bits};
    job.data[2] = item.stick_x;
    job.data[3] = item.stick_y;
    job.data[4] = item.cstick_x;
    job.data[5] = item.cstick_y;
    job.data[6] = item.trigger_left;
    job.data[7] = item.trigger_right;
    if (byte_done) begin
      case (phase)
        CMD_BYTE: begin
          if (new_byte == jbcr_pkg::CMD_POLL) begin
            job_push = 1'b1;
            job.kind = jbcr_pkg::REPLY_POLL;
          end else if (new_byte == jbcr_pkg::CMD_ORIGIN) begin
            job_push = 1'b1;
            job.kind = jbcr_pkg::REPLY_ORIGIN;
          end
        end
        MID_BYTE: begin
          job_push = 1'b0;
        end
        default: begin
          job_push = 1'b1;
          job.kind = jbcr_pkg::REPLY_STATUS;
          job.rumble = new_byte[0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= CMD_BYTE;
      pair_index <= 2'd0;
      partial_byte <= 6'd0;
      rumble_state <= 1'b0;
      face_button_mask <= 16'd0;
      shoulder_button_mask <= 16'd0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == jbcr_pkg::REG_FACE_MASK) begin
          face_button_mask <= cfg_data;
        end else if (cfg_index == jbcr_pkg::REG_SHOULDER_MASK) begin
          shoulder_button_mask <= cfg_data;
        end
      end
      if (accept) begin
        if (is_stop) begin
          phase <= CMD_BYTE;
          pair_index <= 2'd0;
          partial_byte <= 6'd0;
        end else begin
          pair_index <= pair_index + 2'd1;
          partial_byte <= byte_done ? 6'd0 : new_byte[5:0];
        end
      end
      if (byte_done) begin
        case (phase)
          CMD_BYTE: begin
            if (new_byte == jbcr_pkg::CMD_STATUS) begin
              phase <= MID_BYTE;
            end
          end
          MID_BYTE: begin
            phase <= LAST_BYTE;
          end
          default: begin
            phase <= CMD_BYTE;
            rumble_state <= new_byte[0];
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[design/jbcr_queue.sv]
// ----------------------------------------------------------------------------
// Controller responder job queue
// Two-entry queue of reply jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jbcr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire jbcr_pkg::reply_job_t push_job,
  input  wire logic                 pop,
  output      logic                 full,
  output      logic                 head_valid,
  output      jbcr_pkg::reply_job_t head_job
);

  jbcr_pkg::reply_job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/jbcr_back.sv]
// ----------------------------------------------------------------------------
// Controller responder back end
// Serializes the head reply job into transmit symbols through an output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joybus_controller_responder_core_defines.svh"

module jbcr_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 head_valid,
  input  wire jbcr_pkg::reply_job_t head_job,
  output      logic                 job_pop,
  input  wire logic                 pop,
  output      logic                 empty,
  output      jbcr_pkg::out_item_t  result
);

  logic [5:0]  idx;
  logic        out_valid;
  logic [3:0]  nbytes;
  logic [5:0]  limit;
  logic [3:0]  byte_sel;
  logic [7:0]  cur_byte;
  logic [1:0]  pair;
  logic        at_end;
  logic        advance;
  jbcr_pkg::out_item_t sym;

  always_comb begin
    byte_sel = idx[5:2];
    case (head_job.kind)
      jbcr_pkg::REPLY_POLL: begin
        nbytes = jbcr_pkg::POLL_BYTES;
        cur_byte = jbcr_pkg::poll_byte(byte_sel);
      end
      jbcr_pkg::REPLY_ORIGIN: begin
        nbytes = jbcr_pkg::ORIGIN_BYTES;
        cur_byte = jbcr_pkg::origin_byte(byte_sel);
      end
      default: begin
        nbytes = jbcr_pkg::STATUS_BYTES;
        cur_byte = head_job.data[byte_sel[2:0]];
      end
    endcase
    limit = {nbytes, 2'b00};
    at_end = (idx == limit);
    case (idx[1:0])
      2'd0: pair = cur_byte[7:6];
      2'd1: pair = cur_byte[5:4];
      2'd2: pair = cur_byte[3:2];
      default: pair = cur_byte[1:0];
    endcase
    sym.tx_symbol = at_end ? jbcr_pkg::TX_STOP : jbcr_pkg::pair_code(pair);
    sym.last_symbol = at_end;
    sym.rumble_on = head_job.rumble;
    advance = head_valid && (!out_valid || pop);
    job_pop = advance && at_end;
    empty = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx <= at_end ? 6'd0 : idx + 6'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= sym;
    end
  end

  `JBCR_ASSERT(a_idx_in_range, clk, rst, head_valid |-> idx <= limit)
  `JBCR_ASSERT(a_idx_idle_zero, clk, rst, !head_valid |-> idx == 6'd0)
  `JBCR_NEVER(a_last_is_stop, clk, rst, out_valid && result.last_symbol && result.tx_symbol != jbcr_pkg::TX_STOP)

endmodule

`default_nettype wire

[design/joybus_controller_responder_core.sv]
// ----------------------------------------------------------------------------
// Controller responder core
// Accepts received bus symbols, answers commands with transmit symbols.
// ----------------------------------------------------------------------------
// Reply: the first reply symbol is registered in the output stage once a job is
// queued; symbols follow at one per cycle while pop is high and a job is queued.
// Throughput: one received symbol per cycle; input stalls only while two reply
// jobs (up to 41 symbols each) wait in the job queue.
// Reset: synchronous, clears assembly state, rumble, both masks, queue, out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module joybus_controller_responder_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output      logic                             full,
  input  wire jbcr_pkg::in_item_t               item,
  output      logic                             empty,
  input  wire logic                             pop,
  output      jbcr_pkg::out_item_t              result,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [jbcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_data
);

  logic                 accept;
  logic                 job_push;
  jbcr_pkg::reply_job_t push_job;
  logic                 job_pop;
  logic                 head_valid;
  jbcr_pkg::reply_job_t head_job;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;

  jbcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (push_job)
  );

  jbcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  jbcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .job_pop    (job_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

`default_nettype wire
